### hw/rtl/sac_pkg.sv
// package for the set-associative write-back cache unit
// sizes, address field widths, function codes and item structs; no dependencies

package sac_pkg;

  localparam int unsigned NUM_SETS       = 2;
  localparam int unsigned NUM_WAYS       = 4;
  localparam int unsigned BYTES_PER_LINE = 4;
  localparam int unsigned MEM_BLOCKS     = 32;

  localparam int unsigned NUM_LINES = NUM_SETS * NUM_WAYS;
  localparam int unsigned MEM_BYTES = MEM_BLOCKS * BYTES_PER_LINE;
  localparam int unsigned LD_BYTES  = NUM_LINES * BYTES_PER_LINE;

  localparam int unsigned OFF_W  = $clog2(BYTES_PER_LINE);
  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
  localparam int unsigned LINE_W = SET_W + WAY_W;
  localparam int unsigned BLK_W  = $clog2(MEM_BLOCKS);
  localparam int unsigned ADDR_W = BLK_W + OFF_W;
  localparam int unsigned TAG_W  = BLK_W - SET_W;
  localparam int unsigned LD_AW  = LINE_W + OFF_W;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned BCNT_W = OFF_W + 1;

  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_PRELOAD = 2'd2;

  localparam int unsigned CNT_RD_HIT  = 0;
  localparam int unsigned CNT_RD_MISS = 1;
  localparam int unsigned CNT_WR_HIT  = 2;
  localparam int unsigned CNT_WR_MISS = 3;
  localparam int unsigned NUM_CNT     = 4;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
  } sac_in_t;

  typedef struct packed {
    logic              hit;
    logic [7:0]        read_data;
    logic [LINE_W-1:0] cache_line;
    logic [BLK_W-1:0]  block_number;
    logic              wrote_back;
    logic [BLK_W-1:0]  victim_block;
    logic [CNT_W-1:0]  read_hit_count;
    logic [CNT_W-1:0]  read_miss_count;
    logic [CNT_W-1:0]  write_hit_count;
    logic [CNT_W-1:0]  write_miss_count;
  } sac_out_t;

endpackage

### hw/rtl/set_assoc_fifo_writeback_cache_unit.sv
// top level of the set-associative fifo-replacement write-back cache unit
// uses sac_pkg and two sac_ram instances (backing memory and line data)

// One item at a time: in_ready_o is high only while the sequencer is idle. A
// preload, a write hit or an unused code goes from lookup straight to the
// result, a read hit first reads its byte from the line data, and a miss
// refills the line through the byte-wide memory port, after first copying a
// dirty victim back. The result waits in an output register, so the next
// item can be accepted while it is still pending. Backing memory is not
// cleared: reading a byte that was never preloaded or written back gives
// undefined data.

module set_assoc_fifo_writeback_cache_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sac_pkg::sac_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sac_pkg::sac_out_t out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_HRD  = 6'b000100,
    S_WB   = 6'b001000,
    S_FILL = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  sac_pkg::sac_in_t req_q;
  logic [sac_pkg::TAG_W-1:0]  tag_q [sac_pkg::NUM_LINES];
  logic [sac_pkg::NUM_LINES-1:0] valid_q, dirty_q;
  logic [sac_pkg::WAY_W-1:0]  fifo_q [sac_pkg::NUM_SETS];
  logic [sac_pkg::CNT_W-1:0]  cnt_q [sac_pkg::NUM_CNT];
  logic [sac_pkg::BCNT_W-1:0] bcnt_q;

  logic                       hit_q, wb_q;
  logic [7:0]                 rdata_q;
  logic [sac_pkg::LINE_W-1:0] line_q;
  logic [sac_pkg::BLK_W-1:0]  victim_q;

  logic                     out_valid_q;
  sac_pkg::sac_out_t        out_q;

  logic [sac_pkg::OFF_W-1:0] req_off;
  logic [sac_pkg::SET_W-1:0] req_set;
  logic [sac_pkg::TAG_W-1:0] req_tag;
  logic [sac_pkg::BLK_W-1:0] req_blk;
  logic                      is_write, is_access;

  logic                       hit_c;
  logic [sac_pkg::WAY_W-1:0]  hway_c, vway_c;
  logic [sac_pkg::LINE_W-1:0] hline_c, vline_c, lidx;
  logic [sac_pkg::OFF_W-1:0]  bidx, bidx_m1;
  logic                       bcnt_zero, bcnt_last;

  logic                       mem_we;
  logic [sac_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]                 mem_wdata, mem_rdata;
  logic                       ld_we;
  logic [sac_pkg::LD_AW-1:0]  ld_waddr, ld_raddr;
  logic [7:0]                 ld_wdata, ld_rdata;
  logic [7:0]                 fill_byte;

  assign req_off   = req_q.address[sac_pkg::OFF_W-1:0];
  assign req_blk   = req_q.address[sac_pkg::ADDR_W-1:sac_pkg::OFF_W];
  assign req_set   = req_q.address[sac_pkg::OFF_W +: sac_pkg::SET_W];
  assign req_tag   = req_q.address[sac_pkg::ADDR_W-1:sac_pkg::OFF_W+sac_pkg::SET_W];
  assign is_write  = (req_q.func == sac_pkg::FUNC_WRITE);
  assign is_access = (req_q.func == sac_pkg::FUNC_READ) || is_write;

  // tag compare over the ways of the set, lowest way wins
  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
      lidx = {req_set, sac_pkg::WAY_W'(w)};
      if (!hit_c && valid_q[lidx] && (tag_q[lidx] == req_tag)) begin
        hit_c  = 1'b1;
        hway_c = sac_pkg::WAY_W'(w);
      end
    end
  end

  assign vway_c    = fifo_q[req_set];
  assign hline_c   = {req_set, hway_c};
  assign vline_c   = {req_set, vway_c};
  assign bidx      = bcnt_q[sac_pkg::OFF_W-1:0];
  assign bidx_m1   = sac_pkg::OFF_W'(bcnt_q - sac_pkg::BCNT_W'(1));
  assign bcnt_zero = (bcnt_q == '0);
  assign bcnt_last = (bcnt_q == sac_pkg::BCNT_W'(sac_pkg::BYTES_PER_LINE));

  // write miss merges its byte while the line is refilled
  assign fill_byte = (is_write && (bidx_m1 == req_off)) ? req_q.write_data : mem_rdata;

  always_comb begin
    mem_we    = ((state_q == S_LOOK) && (req_q.func == sac_pkg::FUNC_PRELOAD)) ||
                ((state_q == S_WB) && !bcnt_zero);
    mem_waddr = (state_q == S_LOOK) ? req_q.address : {victim_q, bidx_m1};
    mem_wdata = (state_q == S_LOOK) ? req_q.write_data : ld_rdata;
    mem_raddr = {req_blk, bidx};

    ld_we     = ((state_q == S_LOOK) && hit_c && is_write) ||
                ((state_q == S_FILL) && !bcnt_zero);
    ld_waddr  = (state_q == S_LOOK) ? {hline_c, req_off} : {line_q, bidx_m1};
    ld_wdata  = (state_q == S_LOOK) ? req_q.write_data : fill_byte;
    ld_raddr  = (state_q == S_LOOK) ? {hline_c, req_off} : {line_q, bidx};
  end

  sac_ram #(
    .DEPTH (sac_pkg::MEM_BYTES),
    .WIDTH (8)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sac_ram #(
    .DEPTH (sac_pkg::LD_BYTES),
    .WIDTH (8)
  ) u_line_data (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        if (!is_access || (hit_c && is_write)) begin
          state_d = S_DONE;
        end else if (hit_c) begin
          state_d = S_HRD;
        end else if (valid_q[vline_c] && dirty_q[vline_c]) begin
          state_d = S_WB;
        end else begin
          state_d = S_FILL;
        end
      end
      S_HRD:  state_d = S_DONE;
      S_WB:   if (bcnt_last) state_d = S_FILL;
      S_FILL: if (bcnt_last) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < sac_pkg::NUM_SETS; s++) fifo_q[s] <= '0;
      for (int c = 0; c < sac_pkg::NUM_CNT; c++) cnt_q[c] <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOOK: begin
          bcnt_q <= '0;
          if (is_access) begin
            if (hit_c) begin
              if (is_write) begin
                dirty_q[hline_c] <= 1'b1;
                if (cnt_q[sac_pkg::CNT_WR_HIT] != '1) begin
                  cnt_q[sac_pkg::CNT_WR_HIT] <= cnt_q[sac_pkg::CNT_WR_HIT] + 1'b1;
                end
              end else if (cnt_q[sac_pkg::CNT_RD_HIT] != '1) begin
                cnt_q[sac_pkg::CNT_RD_HIT] <= cnt_q[sac_pkg::CNT_RD_HIT] + 1'b1;
              end
            end else begin
              fifo_q[req_set] <= vway_c + 1'b1;
              if (is_write) begin
                if (cnt_q[sac_pkg::CNT_WR_MISS] != '1) begin
                  cnt_q[sac_pkg::CNT_WR_MISS] <= cnt_q[sac_pkg::CNT_WR_MISS] + 1'b1;
                end
              end else if (cnt_q[sac_pkg::CNT_RD_MISS] != '1) begin
                cnt_q[sac_pkg::CNT_RD_MISS] <= cnt_q[sac_pkg::CNT_RD_MISS] + 1'b1;
              end
            end
          end
        end
        S_WB: begin
          bcnt_q <= bcnt_last ? '0 : bcnt_q + 1'b1;
        end
        S_FILL: begin
          bcnt_q <= bcnt_q + 1'b1;
          if (bcnt_last) begin
            valid_q[line_q] <= 1'b1;
            dirty_q[line_q] <= is_write;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) req_q <= in_data_i;
    case (state_q)
      S_LOOK: begin
        hit_q    <= is_access && hit_c;
        wb_q     <= is_access && !hit_c && valid_q[vline_c] && dirty_q[vline_c];
        victim_q <= {tag_q[vline_c], req_set};
        line_q   <= !is_access ? '0 : (hit_c ? hline_c : vline_c);
        rdata_q  <= (is_write || (req_q.func == sac_pkg::FUNC_PRELOAD)) ?
                    req_q.write_data : 8'h00;
        if (is_access && !hit_c) tag_q[vline_c] <= req_tag;
      end
      S_HRD:  rdata_q <= ld_rdata;
      S_FILL: if (!bcnt_zero && (bidx_m1 == req_off)) rdata_q <= fill_byte;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.hit              <= hit_q;
          out_q.read_data        <= rdata_q;
          out_q.cache_line       <= line_q;
          out_q.block_number     <= req_blk;
          out_q.wrote_back       <= wb_q;
          out_q.victim_block     <= wb_q ? victim_q : '0;
          out_q.read_hit_count   <= cnt_q[sac_pkg::CNT_RD_HIT];
          out_q.read_miss_count  <= cnt_q[sac_pkg::CNT_RD_MISS];
          out_q.write_hit_count  <= cnt_q[sac_pkg::CNT_WR_HIT];
          out_q.write_miss_count <= cnt_q[sac_pkg::CNT_WR_MISS];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/sac_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module sac_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/sac_chk.sv
// port-level checker for set_assoc_fifo_writeback_cache_unit, with its bind
// uses sac_pkg for the item structs

module sac_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sac_pkg::sac_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sac_pkg::sac_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> !out_data_o.wrote_back)
    else $error("hit reported a write-back");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.wrote_back |-> out_data_o.victim_block == '0)
    else $error("victim block without write-back");

endmodule

bind set_assoc_fifo_writeback_cache_unit sac_chk u_sac_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
